>>> sv/ipcf_pkg.sv
// Shared types, constants and the CORDIC angle table for the pitch filter.
// No dependencies; used by ipcf_cordic and imu_pitch_complementary_filter.
package ipcf_pkg;

  localparam int CordicSteps = 16;
  localparam int DpW         = 36;   // CORDIC datapath width
  localparam int DivBits     = 54;   // dividend width of the time-step division

  localparam logic signed [31:0] InvGainQ30  = 32'sd652032874;
  localparam logic signed [31:0] Deg2RadQ30  = 32'sd18740330;
  localparam logic signed [19:0] RateLimit   = 20'sd327942;
  localparam logic signed [24:0] PitchLimit  = 25'sd11796480;
  localparam logic [19:0]        UsPerSecond = 20'd1000000;
  localparam logic [19:0]        HalfSecond  = 20'd500000;

  // 2^50 / 10^6 rounded down (first estimate) and up (remainder correction)
  localparam logic signed [31:0] RecipLoQ50  = 32'sd1125899906;
  localparam logic signed [31:0] RecipHiQ50  = 32'sd1125899907;

  // configuration register indexes
  localparam logic [1:0] RegBlendWeight = 2'd0;
  localparam logic [1:0] RegRateOffset  = 2'd1;
  localparam logic [1:0] RegRateScale   = 2'd2;

  localparam logic [15:0] BlendWeightRst = 16'd64225;
  localparam logic [23:0] RateScaleRst   = 24'd146801;

  // one CORDIC vector: x, y and accumulated angle (degrees Q24)
  typedef struct packed {
    logic signed [DpW-1:0] x;
    logic signed [DpW-1:0] y;
    logic signed [DpW-1:0] z;
  } cordic_t;

  // atan(2^-i) in degrees Q24
  function automatic logic signed [DpW-1:0] atan_deg(input logic [3:0] idx);
    logic signed [DpW-1:0] v;
    case (idx)
      4'd0:    v = 36'sd754974720;
      4'd1:    v = 36'sd445687602;
      4'd2:    v = 36'sd235489088;
      4'd3:    v = 36'sd119537938;
      4'd4:    v = 36'sd60000934;
      4'd5:    v = 36'sd30029717;
      4'd6:    v = 36'sd15018523;
      4'd7:    v = 36'sd7509720;
      4'd8:    v = 36'sd3754917;
      4'd9:    v = 36'sd1877466;
      4'd10:   v = 36'sd938734;
      4'd11:   v = 36'sd469367;
      4'd12:   v = 36'sd234684;
      4'd13:   v = 36'sd117342;
      4'd14:   v = 36'sd58671;
      4'd15:   v = 36'sd29335;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/imu_pitch_complementary_filter.sv
// Pitch complementary filter top level: sequencer, shared multiplier, CORDIC.
// Depends on ipcf_pkg and ipcf_cordic.

// Each transaction is accepted only while the block is idle and gives one
// result after fixed-point rate math on one shared multiplier (gyro scaling,
// rad/s conversion, integration product and the divide by 10^6 done as a
// reciprocal multiply with one remainder correction), a 16-step vectoring pass
// for the magnitude, the magnitude gain correction, a 16-step vectoring pass
// for the accelerometer angle, blending and rotation load, a 16-step rotation
// pass for the half-angle sin/cos, and the load of the output register. The
// input is ready again the cycle after the output register is loaded, so a new
// transaction can start while the previous result waits to be taken; if that
// result is still waiting when the next one is done, the block holds in its
// last state and the input stays not ready. Configuration takes effect on the
// next transaction only if the user writes it between transactions; the block
// reads it live and does not enforce this.
module imu_pitch_complementary_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_y[63:48], elapsed_us[83:64]
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pitch_deg[24:0], quat_w[40:25], quat_y[56:41], rate_rad[76:57]
  output logic [79:0] m_tdata
);

  localparam int Dp        = ipcf_pkg::DpW;
  localparam int DivBits_w = ipcf_pkg::DivBits;

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001, S_CORR  = 21'h000002, S_DEGS  = 21'h000004,
    S_RAD   = 21'h000008, S_DT    = 21'h000010, S_LOAD  = 21'h000020,
    S_QEST  = 21'h000040, S_QMUL  = 21'h000080, S_QREM  = 21'h000100,
    S_QFIX  = 21'h000200, S_QSUM  = 21'h000400, S_VEC1  = 21'h000800,
    S_MMUL  = 21'h001000, S_MAG   = 21'h002000, S_VEC2  = 21'h004000,
    S_B1    = 21'h008000, S_B2    = 21'h010000, S_BLEND = 21'h020000,
    S_RLD   = 21'h040000, S_ROT   = 21'h080000, S_DONE  = 21'h100000
  } state_t;

  state_t state;

  // configuration
  logic [15:0]        blend_weight;
  logic signed [19:0] rate_offset;
  logic [23:0]        rate_scale;

  // captured item
  logic signed [15:0] ax, ay, az, gy;
  logic [19:0]        dt;

  // working registers
  logic [3:0]               cnt;
  logic signed [67:0]       prod, acc;
  logic signed [33:0]       degs;
  logic signed [19:0]       rate;
  logic [DivBits_w-1:0]     dq;
  logic [33:0]              quo;
  logic [23:0]              rem;
  logic                     neg, zero_vec;
  logic signed [Dp-1:0]     base;
  logic signed [27:0]       accel_p;
  logic signed [24:0]       pitch;
  ipcf_pkg::cordic_t        cv, cv_next;

  // shared multiplier operands
  logic signed [Dp-1:0] mul_a;
  logic signed [31:0]   mul_b;
  logic signed [67:0]   mul_p;

  // helpers
  logic signed [21:0] corr;
  logic signed [67:0] prod_abs;
  logic signed [Dp-1:0] step;
  logic signed [68:0] blend_sum;
  logic signed [52:0] blend_rnd;
  logic signed [37:0] rate_rnd;
  logic signed [Dp-1:0] mag;
  logic signed [Dp-1:0] qw_rnd, qy_rnd;
  logic signed [15:0] qw, qy;
  logic               out_load;

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  ipcf_cordic u_cordic (
    .vec_mode (state == S_VEC1 || state == S_VEC2),
    .idx      (cnt),
    .cin      (cv),
    .cout     (cv_next)
  );

  // operand select for the one multiplier
  always_comb begin
    corr  = {{2{gy[15]}}, gy, 4'b0} - {{2{rate_offset[19]}}, rate_offset};
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CORR: begin
        mul_a = Dp'(corr);
        mul_b = $signed({8'b0, rate_scale});
      end
      S_RAD: begin
        mul_a = Dp'(degs);
        mul_b = ipcf_pkg::Deg2RadQ30;
      end
      S_DT: begin
        mul_a = Dp'(degs);
        mul_b = $signed({12'b0, dt});
      end
      S_QEST: begin
        mul_a = $signed({2'b0, dq[DivBits_w-1:20]});
        mul_b = ipcf_pkg::RecipLoQ50;
      end
      S_QMUL: begin
        mul_a = Dp'(prod >>> 30);
        mul_b = $signed({12'b0, ipcf_pkg::UsPerSecond});
      end
      S_QFIX: begin
        mul_a = $signed({12'b0, rem});
        mul_b = ipcf_pkg::RecipHiQ50;
      end
      S_MMUL: begin
        mul_a = cv.x;
        mul_b = ipcf_pkg::InvGainQ30;
      end
      S_B1: begin
        mul_a = base;
        mul_b = $signed({16'b0, blend_weight});
      end
      S_B2: begin
        mul_a = Dp'(accel_p);
        mul_b = $signed(32'h0001_0000 - {16'b0, blend_weight});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // rounding and saturation
  always_comb begin
    prod_abs  = prod[67] ? -prod : prod;
    step      = neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
    blend_sum = {acc[67], acc} + {prod[67], prod};
    blend_rnd = 53'((blend_sum + 69'sd32768) >>> 16);
    rate_rnd  = 38'((prod + 68'sd536870912) >>> 30);
    mag       = Dp'((prod + 68'sd536870912) >>> 30);
    qw_rnd    = (cv.x + 36'sd16384) >>> 15;
    qy_rnd    = (cv.y + 36'sd16384) >>> 15;
    if (qw_rnd > 36'sd32767)       qw = 16'sd32767;
    else if (qw_rnd < -36'sd32768) qw = -16'sd32768;
    else                           qw = qw_rnd[15:0];
    if (qy_rnd > 36'sd32767)       qy = 16'sd32767;
    else if (qy_rnd < -36'sd32768) qy = -16'sd32768;
    else                           qy = qy_rnd[15:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= ipcf_pkg::BlendWeightRst;
      rate_offset  <= '0;
      rate_scale   <= ipcf_pkg::RateScaleRst;
    end else if (cfg_we) begin
      case (cfg_index)
        ipcf_pkg::RegBlendWeight: blend_weight <= cfg_data[15:0];
        ipcf_pkg::RegRateOffset:  rate_offset  <= $signed(cfg_data[19:0]);
        ipcf_pkg::RegRateScale:   rate_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tdata  <= {3'b0, rate, qy, qw, pitch};
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pitch <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ax    <= $signed(s_tdata[15:0]);
            ay    <= $signed(s_tdata[31:16]);
            az    <= $signed(s_tdata[47:32]);
            gy    <= $signed(s_tdata[63:48]);
            dt    <= s_tdata[83:64];
            state <= S_CORR;
          end
        end
        S_CORR: begin
          prod  <= mul_p;
          state <= S_DEGS;
        end
        S_DEGS: begin
          degs  <= 34'((prod + 68'sd2048) >>> 12);
          state <= S_RAD;
        end
        S_RAD: begin
          prod  <= mul_p;
          state <= S_DT;
        end
        S_DT: begin
          if (rate_rnd > 38'(ipcf_pkg::RateLimit))       rate <= ipcf_pkg::RateLimit;
          else if (rate_rnd < -38'(ipcf_pkg::RateLimit)) rate <= -ipcf_pkg::RateLimit;
          else                                           rate <= rate_rnd[19:0];
          prod  <= mul_p;
          state <= S_LOAD;
        end
        S_LOAD: begin
          neg   <= prod[67];
          dq    <= prod_abs[DivBits_w-1:0] + DivBits_w'(ipcf_pkg::HalfSecond);
          state <= S_QEST;
        end
        // divide by 10^6: low estimate, remainder, then exact remainder quotient
        S_QEST: begin
          prod  <= mul_p;
          state <= S_QMUL;
        end
        S_QMUL: begin
          quo   <= 34'(prod >>> 30);
          prod  <= mul_p;
          state <= S_QREM;
        end
        S_QREM: begin
          rem   <= 24'(dq - prod[DivBits_w-1:0]);
          state <= S_QFIX;
        end
        S_QFIX: begin
          prod  <= mul_p;
          state <= S_QSUM;
        end
        S_QSUM: begin
          quo   <= quo + 34'(prod >>> 50);
          cnt   <= '0;
          cv.x  <= Dp'(ay[15] ? -32'(ay) : 32'(ay)) <<< 14;
          cv.y  <= Dp'(az[15] ? -32'(az) : 32'(az)) <<< 14;
          cv.z  <= '0;
          state <= S_VEC1;
        end
        S_VEC1: begin
          cv <= cv_next;
          if (cnt == 4'(ipcf_pkg::CordicSteps - 1)) begin
            cnt   <= '0;
            state <= S_MMUL;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_MMUL: begin
          prod  <= mul_p;
          base  <= Dp'(pitch) + step;
          state <= S_MAG;
        end
        S_MAG: begin
          zero_vec <= (mag == '0) && (ax == '0);
          cv.x     <= mag;
          cv.y     <= Dp'(ax) <<< 14;
          cv.z     <= '0;
          cnt      <= '0;
          state    <= S_VEC2;
        end
        S_VEC2: begin
          cv <= cv_next;
          if (cnt == 4'(ipcf_pkg::CordicSteps - 1)) begin
            cnt   <= '0;
            state <= S_B1;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_B1: begin
          accel_p <= zero_vec ? '0 : 28'((cv.z + 36'sd128) >>> 8);
          prod    <= mul_p;
          state   <= S_B2;
        end
        S_B2: begin
          acc   <= prod;
          prod  <= mul_p;
          state <= S_BLEND;
        end
        S_BLEND: begin
          if (blend_rnd > 53'(ipcf_pkg::PitchLimit))       pitch <= ipcf_pkg::PitchLimit;
          else if (blend_rnd < -53'(ipcf_pkg::PitchLimit)) pitch <= -ipcf_pkg::PitchLimit;
          else                                             pitch <= blend_rnd[24:0];
          state <= S_RLD;
        end
        S_RLD: begin
          cv.x  <= Dp'(ipcf_pkg::InvGainQ30);
          cv.y  <= '0;
          cv.z  <= Dp'(pitch) <<< 7;
          cnt   <= '0;
          state <= S_ROT;
        end
        // rotation pass for the half-angle sin/cos
        S_ROT: begin
          cv <= cv_next;
          if (cnt == 4'(ipcf_pkg::CordicSteps - 1)) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ipcf_cordic.sv
// One CORDIC micro-rotation, shared by the vectoring and rotation passes.
// Depends on ipcf_pkg for the vector type and the angle table.
module ipcf_cordic (
  input  logic             vec_mode,
  input  logic [3:0]       idx,
  input  ipcf_pkg::cordic_t cin,
  output ipcf_pkg::cordic_t cout
);

  logic signed [ipcf_pkg::DpW-1:0] xs, ys, at;
  logic                            ccw;

  // vectoring drives y to zero, rotation drives z to zero
  always_comb begin
    xs  = cin.x >>> idx;
    ys  = cin.y >>> idx;
    at  = ipcf_pkg::atan_deg(idx);
    ccw = vec_mode ? cin.y[ipcf_pkg::DpW-1] : ~cin.z[ipcf_pkg::DpW-1];
    if (ccw) begin
      cout.x = cin.x - ys;
      cout.y = cin.y + xs;
      cout.z = cin.z - at;
    end else begin
      cout.x = cin.x + ys;
      cout.y = cin.y - xs;
      cout.z = cin.z + at;
    end
  end

endmodule
